// ===== rtl/ffd_pkg.sv =====
// Shared types and constants for the fixed frame deframer.
package ffd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned POS_W   = 3;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned BODY_N  = 4;
	localparam int unsigned BODY_IW = 2;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
	localparam logic [IDX_W-1:0] REG_HEADER_SECOND = 8'd1;
	localparam logic [IDX_W-1:0] REG_TAIL_FIRST    = 8'd2;
	localparam logic [IDX_W-1:0] REG_TAIL_SECOND   = 8'd3;

	// Register reset values
	localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'd170;
	localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'd85;
	localparam logic [BYTE_W-1:0] RST_TAIL_FIRST    = 8'd13;
	localparam logic [BYTE_W-1:0] RST_TAIL_SECOND   = 8'd10;

	// Frame positions
	localparam logic [POS_W-1:0] POS_HUNT      = 3'd0;
	localparam logic [POS_W-1:0] POS_HEADER2   = 3'd1;
	localparam logic [POS_W-1:0] POS_BODY      = 3'd2;
	localparam logic [POS_W-1:0] POS_TAIL2     = 3'd6;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_VALID   = 2'd1,
		EV_INVALID = 2'd2
	} event_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header_first;
		logic [BYTE_W-1:0] header_second;
		logic [BYTE_W-1:0] tail_first;
		logic [BYTE_W-1:0] tail_second;
	} cfg_t;

	typedef struct packed {
		event_t              ev;
		logic [DIST_W-1:0]   distance;
		logic [BYTE_W-1:0]   reserved_byte;
		logic [COUNT_W-1:0]  valid_count;
		logic [COUNT_W-1:0]  invalid_count;
	} result_t;

endpackage

// ===== rtl/ffd_cfg.sv =====
// Configuration register file for the frame match bytes.
module ffd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [ffd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ffd_pkg::BYTE_W-1:0]  cfg_data,
	output ffd_pkg::cfg_t               cfg
);

	ffd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= ffd_pkg::RST_HEADER_FIRST;
			cfg_q.header_second <= ffd_pkg::RST_HEADER_SECOND;
			cfg_q.tail_first    <= ffd_pkg::RST_TAIL_FIRST;
			cfg_q.tail_second   <= ffd_pkg::RST_TAIL_SECOND;
		end else if (cfg_wen) begin
			// drop writes to indexes beyond the register list
			if (cfg_index == ffd_pkg::REG_HEADER_FIRST) begin
				cfg_q.header_first <= cfg_data;
			end
			if (cfg_index == ffd_pkg::REG_HEADER_SECOND) begin
				cfg_q.header_second <= cfg_data;
			end
			if (cfg_index == ffd_pkg::REG_TAIL_FIRST) begin
				cfg_q.tail_first <= cfg_data;
			end
			if (cfg_index == ffd_pkg::REG_TAIL_SECOND) begin
				cfg_q.tail_second <= cfg_data;
			end
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ffd_core.sv =====
// Frame tracker: position, body bytes, held values and saturating counters.
module ffd_core #(
	parameter int unsigned COUNTER_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [ffd_pkg::BYTE_W-1:0]  rx_byte,
	input  ffd_pkg::cfg_t               cfg,
	output ffd_pkg::result_t            result
);

	logic [ffd_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [ffd_pkg::BYTE_W-1:0]  body_q [ffd_pkg::BODY_N];
	logic [COUNTER_BITS-1:0]     good_q, good_d, bad_q, bad_d;
	logic [ffd_pkg::DIST_W-1:0]  dist_q, dist_d;
	logic [ffd_pkg::BYTE_W-1:0]  rsvd_q, rsvd_d;
	logic                        body_we;
	logic [ffd_pkg::POS_W-1:0]   body_off;
	logic [ffd_pkg::BODY_IW-1:0] body_idx;
	logic                        good_inc, bad_inc, hdr1_hit;
	ffd_pkg::event_t             ev;
	logic [ffd_pkg::COUNT_W-1:0] good_out, bad_out;

	assign body_off = pos_q - ffd_pkg::POS_BODY;
	assign body_idx = body_off[ffd_pkg::BODY_IW-1:0];
	assign hdr1_hit = (rx_byte == cfg.header_first);

	always_comb begin
		pos_d    = pos_q;
		dist_d   = dist_q;
		rsvd_d   = rsvd_q;
		body_we  = 1'b0;
		good_inc = 1'b0;
		bad_inc  = 1'b0;
		ev       = ffd_pkg::EV_NONE;
		priority if (pos_q == ffd_pkg::POS_HUNT) begin
			if (hdr1_hit) begin
				pos_d = ffd_pkg::POS_HEADER2;
			end
		end else if (pos_q == ffd_pkg::POS_HEADER2) begin
			if (rx_byte == cfg.header_second) begin
				pos_d = ffd_pkg::POS_BODY;
			end else begin
				bad_inc = 1'b1;
				ev      = ffd_pkg::EV_INVALID;
				// a repeated first header byte opens a new frame
				pos_d   = hdr1_hit ? ffd_pkg::POS_HEADER2 : ffd_pkg::POS_HUNT;
			end
		end else if (pos_q < ffd_pkg::POS_TAIL2) begin
			body_we = 1'b1;
			pos_d   = pos_q + 3'd1;
		end else begin
			if (body_q[3] == cfg.tail_first && rx_byte == cfg.tail_second) begin
				dist_d   = {body_q[0], body_q[1]};
				rsvd_d   = body_q[2];
				good_inc = 1'b1;
				ev       = ffd_pkg::EV_VALID;
			end else begin
				bad_inc = 1'b1;
				ev      = ffd_pkg::EV_INVALID;
			end
			pos_d = hdr1_hit ? ffd_pkg::POS_HEADER2 : ffd_pkg::POS_HUNT;
		end
	end

	// hold at all ones
	assign good_d = (good_inc && good_q != '1) ? good_q + 1'b1 : good_q;
	assign bad_d  = (bad_inc && bad_q != '1) ? bad_q + 1'b1 : bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= ffd_pkg::POS_HUNT;
			good_q <= '0;
			bad_q  <= '0;
			dist_q <= '0;
			rsvd_q <= '0;
		end else if (advance) begin
			pos_q  <= pos_d;
			good_q <= good_d;
			bad_q  <= bad_d;
			dist_q <= dist_d;
			rsvd_q <= rsvd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && body_we) begin
			body_q[body_idx] <= rx_byte;
		end
	end

	generate
		if (COUNTER_BITS >= ffd_pkg::COUNT_W) begin : g_wide
			assign good_out = good_d[ffd_pkg::COUNT_W-1:0];
			assign bad_out  = bad_d[ffd_pkg::COUNT_W-1:0];
		end else begin : g_narrow
			assign good_out = {{(ffd_pkg::COUNT_W-COUNTER_BITS){1'b0}}, good_d};
			assign bad_out  = {{(ffd_pkg::COUNT_W-COUNTER_BITS){1'b0}}, bad_d};
		end
	endgenerate

	assign result.ev            = ev;
	assign result.distance      = dist_d;
	assign result.reserved_byte = rsvd_d;
	assign result.valid_count   = good_out;
	assign result.invalid_count = bad_out;

endmodule

// ===== rtl/fixed_frame_deframer.sv =====
// Fixed frame deframer: 7-byte header/tail frame sync over received bytes.
// Throughput: one byte per cycle while out_ready is held high; the frame step
// sits between the input register and the result register.
// Reset clears position, counters and held distance/reserved values and
// loads the default match bytes; body bytes are not cleared.
module fixed_frame_deframer #(
	parameter int unsigned COUNTER_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [ffd_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ffd_pkg::BYTE_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ffd_pkg::BYTE_W-1:0]   rx_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   event_res,
	output logic [ffd_pkg::DIST_W-1:0]   distance,
	output logic [ffd_pkg::BYTE_W-1:0]   reserved_byte,
	output logic [ffd_pkg::COUNT_W-1:0]  valid_count,
	output logic [ffd_pkg::COUNT_W-1:0]  invalid_count
);

	logic                        valid_s1;
	logic [ffd_pkg::BYTE_W-1:0]  byte_s1;
	logic                        out_valid_q;
	ffd_pkg::result_t            res_q, res_d;
	ffd_pkg::cfg_t               cfg;
	logic                        advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	ffd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ffd_core #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.result  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = res_q.ev;
	assign distance      = res_q.distance;
	assign reserved_byte = res_q.reserved_byte;
	assign valid_count   = res_q.valid_count;
	assign invalid_count = res_q.invalid_count;

endmodule
